// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers shared by the controller and datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/ttmw_pkg.sv =====
package ttmw_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [7:0] CODE_END     = 8'd0;
  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  localparam logic [7:0] WRAP_COLUMN = 8'd48;

  typedef enum logic [2:0] {
    REG_FONT_WIDTH    = 3'd0,
    REG_FONT_HEIGHT   = 3'd1,
    REG_GLYPHS_PER_ROW = 3'd2,
    REG_FIRST_CODE    = 3'd3,
    REG_CHARSET_BASE  = 3'd4,
    REG_PALETTE       = 3'd5,
    REG_MAP_SEGMENT   = 3'd6
  } ttmw_reg_e;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_RETURN,
    CLS_TAB,
    CLS_NEWLINE,
    CLS_PRINT
  } ttmw_class_e;

  typedef struct packed {
    logic [3:0]  font_width;
    logic [3:0]  font_height;
    logic [6:0]  glyphs_per_row;
    logic [7:0]  first_code;
    logic [10:0] charset_base;
    logic [1:0]  palette;
    logic [3:0]  map_segment;
  } ttmw_cfg_t;

  typedef struct packed {
    logic load;
    logic halt;
    logic tab;
    logic newline;
    logic advance;
    logic div_step;
    logic scale;
    logic base;
    logic emit;
  } ttmw_cmd_t;

  typedef struct packed {
    logic        halted;
    logic        stop;
    ttmw_class_e code_class;
    logic        div_last;
    logic        out_free;
    logic        last_cell;
  } ttmw_sts_t;

  function automatic ttmw_class_e code_class(input logic [7:0] code);
    ttmw_class_e cls;
    case (code)
      CODE_END:     cls = CLS_END;
      CODE_RETURN:  cls = CLS_RETURN;
      CODE_TAB:     cls = CLS_TAB;
      CODE_NEWLINE: cls = CLS_NEWLINE;
      default:      cls = CLS_PRINT;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/ttmw_ctrl.sv =====
`include "assert_macros.svh"

module ttmw_ctrl import ttmw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ttmw_sts_t sts_i,
  output ttmw_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_DIVIDE = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_BASE   = 6'b010000,
    ST_EMIT   = 6'b100000
  } ttmw_state_e;

  ttmw_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (sts_i.halted) begin
          // drop the item
        end else if (sts_i.stop || sts_i.code_class == CLS_END) begin
          cmd_o.halt = 1'b1;
        end else begin
          case (sts_i.code_class)
            CLS_TAB:     cmd_o.tab = 1'b1;
            CLS_NEWLINE: cmd_o.newline = 1'b1;
            CLS_PRINT: begin
              cmd_o.advance = 1'b1;
              state_d       = ST_DIVIDE;
            end
            default: ;
          endcase
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_cell) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The remainder unit runs a full eight steps before scaling.
  `ASSERT_PROP(a_div_len, clk_i, rst_ni, cmd_o.scale |-> $past(cmd_o.div_step, 1) && $past(cmd_o.div_step, 8))

endmodule

// ===== rtl/ttmw_dp.sv =====
`include "assert_macros.svh"

module ttmw_dp import ttmw_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = 48,
  parameter int unsigned TAB_WIDTH      = 4,
  parameter int unsigned ROW_LIMIT      = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ttmw_cfg_t   cfg_i,
  input  ttmw_cmd_t   cmd_i,
  output ttmw_sts_t   sts_o,
  input  logic        in_start_i,
  input  logic [5:0]  in_column_i,
  input  logic [5:0]  in_row_i,
  input  logic [7:0]  in_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_address_o,
  output logic [15:0] out_word_o,
  output logic        out_last_o
);

  logic [3:0] w_c, h_c;
  logic [6:0] r_c;

  always_comb begin
    w_c = (cfg_i.font_width == 4'd0) ? 4'd1 :
          (cfg_i.font_width > 4'd8) ? 4'd8 : cfg_i.font_width;
    h_c = (cfg_i.font_height == 4'd0) ? 4'd1 :
          (cfg_i.font_height > 4'd8) ? 4'd8 : cfg_i.font_height;
    r_c = (cfg_i.glyphs_per_row == 7'd0) ? 7'd1 :
          (cfg_i.glyphs_per_row > 7'd64) ? 7'd64 : cfg_i.glyphs_per_row;
  end

  // Next tab stop for each column below 64, before font scaling.
  logic [6:0] tab_tbl [64];
  for (genvar i = 0; i < 64; i++) begin : g_tab
    assign tab_tbl[i] = 7'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
  end

  logic [7:0]  col_q, row_q;
  logic [5:0]  line_start_q;
  logic        halted_q;
  logic [7:0]  code_q;
  logic [7:0]  g_q;
  logic [7:0]  dvd_q;
  logic [5:0]  rem_q;
  logic [2:0]  div_cnt_q;
  logic [10:0] a_q;
  logic [9:0]  rw_q;
  logic [15:0] tile_col_q, tile_q;
  logic [15:0] addr_col_q, addr_q;
  logic [2:0]  cx_q, cy_q;
  logic        out_valid_q;
  logic [15:0] out_address_q, out_word_q;
  logic        out_last_q;

  logic [7:0]  g_now;
  logic [10:0] tab_col;
  logic [7:0]  col_adv;
  logic [7:0]  row_nl;
  logic [6:0]  rem_sh;
  logic [7:0]  gq;
  logic [15:0] base_sum;
  logic        col_end, last_cell, out_free;

  assign g_now    = code_q - cfg_i.first_code;
  assign tab_col  = {4'd0, tab_tbl[col_q[5:0]]} * {7'd0, w_c};
  assign col_adv  = col_q + {4'd0, w_c};
  assign row_nl   = row_q + {4'd0, h_c};
  assign rem_sh   = {rem_q, dvd_q[7]};
  assign gq       = g_q - {2'd0, rem_q};
  assign base_sum = {5'd0, cfg_i.charset_base} +
                    ({8'd0, g_q} * {12'd0, w_c}) +
                    ({5'd0, a_q} * {12'd0, w_c});
  assign col_end  = ({1'b0, cy_q} == (h_c - 4'd1));
  assign last_cell = col_end && ({1'b0, cx_q} == (w_c - 4'd1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.halted     = halted_q;
    sts_o.stop       = (col_q >= 8'(SCREEN_COLUMNS)) || (row_q >= 8'(ROW_LIMIT));
    sts_o.code_class = code_class(code_q);
    sts_o.div_last   = (div_cnt_q == 3'd7);
    sts_o.out_free   = out_free;
    sts_o.last_cell  = last_cell;
  end

  // Cursor and string state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      line_start_q <= '0;
      halted_q     <= 1'b1;
    end else begin
      if (cmd_i.load && in_start_i) begin
        col_q        <= {2'd0, in_column_i};
        row_q        <= {2'd0, in_row_i};
        line_start_q <= in_column_i;
        halted_q     <= 1'b0;
      end
      if (cmd_i.halt) halted_q <= 1'b1;
      if (cmd_i.tab) col_q <= tab_col[7:0];
      if (cmd_i.newline || (cmd_i.advance && col_adv >= WRAP_COLUMN)) begin
        row_q <= row_nl;
        col_q <= {2'd0, line_start_q};
      end else if (cmd_i.advance) begin
        col_q <= col_adv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.advance) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 3'd1;
    end
  end

  // Glyph arithmetic and cell walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) code_q <= in_code_i;
    if (cmd_i.advance) begin
      g_q        <= g_now;
      dvd_q      <= g_now;
      rem_q      <= '0;
      addr_col_q <= {cfg_i.map_segment, row_q[5:0], col_q[5:0]};
      addr_q     <= {cfg_i.map_segment, row_q[5:0], col_q[5:0]};
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[6:0], 1'b0};
      if (rem_sh >= r_c) begin
        rem_q <= 6'(rem_sh - r_c);
      end else begin
        rem_q <= rem_sh[5:0];
      end
    end
    if (cmd_i.scale) begin
      a_q  <= {3'd0, gq} * {8'd0, 3'(h_c - 4'd1)};
      rw_q <= {3'd0, r_c} * {6'd0, w_c};
    end
    if (cmd_i.base) begin
      tile_col_q <= base_sum;
      tile_q     <= base_sum;
      cx_q       <= '0;
      cy_q       <= '0;
    end
    if (cmd_i.emit) begin
      if (col_end) begin
        cy_q       <= '0;
        cx_q       <= cx_q + 3'd1;
        tile_col_q <= tile_col_q + 16'd1;
        tile_q     <= tile_col_q + 16'd1;
        addr_col_q <= addr_col_q + 16'd1;
        addr_q     <= addr_col_q + 16'd1;
      end else begin
        cy_q   <= cy_q + 3'd1;
        tile_q <= tile_q + {6'd0, rw_q};
        addr_q <= addr_q + 16'd64;
      end
      out_address_q <= addr_q;
      out_word_q    <= tile_q | {cfg_i.palette, 14'd0};
      out_last_q    <= last_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_address_q;
  assign out_word_o    = out_word_q;
  assign out_last_o    = out_last_q;

  // A cell write never overwrites a result that is still waiting.
  `ASSERT_PROP(a_emit_free, clk_i, rst_ni, cmd_i.emit |-> (!out_valid_q || out_ready_i))
  // The remainder unit leaves a value below the charset row length.
  `ASSERT_PROP(a_rem_range, clk_i, rst_ni, cmd_i.scale |-> ({1'b0, rem_q} < r_c))

endmodule

// ===== rtl/text_to_tile_map_writer.sv =====
// Text to tile-map writer. Each request on the slave stream carries one
// character code; tuser set opens a string and loads the cursor from the
// start column and row in the same request. Every printable character yields
// font_width x font_height cell writes on the master stream, glyph column by
// glyph column, tlast on the last write of the character. A printable
// character is accepted, decoded, run through the eight-step bit-serial
// remainder unit that locates the glyph row in the charset, given two steps
// to build the tile index, then yields one cell write per cycle while the
// output register drains. Registers sit on the APB port at 4-byte steps in
// the order font_width, font_height, glyphs_per_charset_row, first_code,
// charset_base, palette_select, map_segment; the user must see that they are
// written only while the block is idle; the block itself does not enforce it.
module text_to_tile_map_writer import ttmw_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = 48,
  parameter int unsigned TAB_WIDTH      = 4,
  parameter int unsigned ROW_LIMIT      = 28
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] start_column, [11:6] start_row, [19:12] char_code, [23:20] zero
  input  logic [23:0]           s_axis_tdata,
  // [0] string_start
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] cell_address, [31:16] cell_word
  output logic [31:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  ttmw_cfg_t cfg_q;
  ttmw_cmd_t cmd;
  ttmw_sts_t sts;
  ttmw_reg_e reg_idx;
  logic      cfg_wr;
  logic [15:0] out_address, out_word;

  assign pready  = 1'b1;
  assign reg_idx = ttmw_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_width     <= 4'd1;
      cfg_q.font_height    <= 4'd1;
      cfg_q.glyphs_per_row <= 7'd32;
      cfg_q.first_code     <= 8'd32;
      cfg_q.charset_base   <= '0;
      cfg_q.palette        <= '0;
      cfg_q.map_segment    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FONT_WIDTH:     cfg_q.font_width     <= pwdata[3:0];
        REG_FONT_HEIGHT:    cfg_q.font_height    <= pwdata[3:0];
        REG_GLYPHS_PER_ROW: cfg_q.glyphs_per_row <= pwdata[6:0];
        REG_FIRST_CODE:     cfg_q.first_code     <= pwdata[7:0];
        REG_CHARSET_BASE:   cfg_q.charset_base   <= pwdata[10:0];
        REG_PALETTE:        cfg_q.palette        <= pwdata[1:0];
        REG_MAP_SEGMENT:    cfg_q.map_segment    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_FONT_WIDTH:     prdata = {28'd0, cfg_q.font_width};
      REG_FONT_HEIGHT:    prdata = {28'd0, cfg_q.font_height};
      REG_GLYPHS_PER_ROW: prdata = {25'd0, cfg_q.glyphs_per_row};
      REG_FIRST_CODE:     prdata = {24'd0, cfg_q.first_code};
      REG_CHARSET_BASE:   prdata = {21'd0, cfg_q.charset_base};
      REG_PALETTE:        prdata = {30'd0, cfg_q.palette};
      REG_MAP_SEGMENT:    prdata = {28'd0, cfg_q.map_segment};
      default:            prdata = '0;
    endcase
  end

  ttmw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttmw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .TAB_WIDTH      (TAB_WIDTH),
    .ROW_LIMIT      (ROW_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_start_i    (s_axis_tuser),
    .in_column_i   (s_axis_tdata[5:0]),
    .in_row_i      (s_axis_tdata[11:6]),
    .in_code_i     (s_axis_tdata[19:12]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_address_o (out_address),
    .out_word_o    (out_word),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_word, out_address};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ttmw_pkg::*;

  localparam int unsigned SCREEN_COLS = 48;
  localparam int unsigned TAB_STEP    = 4;
  localparam int unsigned ROW_STOP    = 28;
  localparam int unsigned IDLE_PCT    = 22;
  // one step past the last register, must be ignored
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(7 * 4);

  typedef struct {
    logic       open;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] code;
  } text_req_t;

  typedef struct {
    logic [15:0] addr;
    logic [15:0] word;
    logic        tail;
  } map_cell_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [5:0] start_column, [11:6] start_row, [19:12] char_code
  logic        s_axis_tuser = 1'b0; // [0] string_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] cell_address, [31:16] cell_word
  logic        m_axis_tlast;

  text_to_tile_map_writer #(
    .SCREEN_COLUMNS(SCREEN_COLS),
    .TAB_WIDTH     (TAB_STEP),
    .ROW_LIMIT     (ROW_STOP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers and the text cursor
  logic [3:0]  glyph_w_reg = 4'd1;
  logic [3:0]  glyph_h_reg = 4'd1;
  logic [6:0]  sheet_stride_reg = 7'd32;
  logic [7:0]  base_code_reg = 8'd32;
  logic [10:0] sheet_base_reg = 11'd0;
  logic [1:0]  pal_reg = 2'd0;
  logic [3:0]  segment_reg = 4'd0;

  logic [7:0] pen_col = 8'd0;
  logic [7:0] pen_row = 8'd0;
  logic [5:0] margin_col = 6'd0;
  logic       text_stopped = 1'b1;

  text_req_t text_backlog[$];
  map_cell_t cells_due[$];
  int unsigned mismatch_count = 0;
  bit calm = 1'b0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic pen_newline(input int unsigned h);
    pen_row = 8'(int'(pen_row) + h);
    pen_col = 8'(margin_col);
  endtask

  // expected cell writes for one accepted character request
  task automatic render_char(input text_req_t rq);
    int unsigned w, h, r, g, base, tile, pos;
    map_cell_t c;
    w = clamp_u(glyph_w_reg, 1, 8);
    h = clamp_u(glyph_h_reg, 1, 8);
    r = clamp_u(sheet_stride_reg, 1, 64);
    if (rq.open) begin
      pen_col = 8'(rq.col);
      pen_row = 8'(rq.row);
      margin_col = rq.col;
      text_stopped = 1'b0;
    end
    if (text_stopped) return;
    if (rq.code == CODE_END || pen_col >= SCREEN_COLS || pen_row >= ROW_STOP) begin
      text_stopped = 1'b1;
      return;
    end
    case (rq.code)
      CODE_RETURN: ;
      CODE_TAB: pen_col = 8'((int'(pen_col) / TAB_STEP + 1) * TAB_STEP * w);
      CODE_NEWLINE: pen_newline(h);
      default: begin
        g = 8'(rq.code - base_code_reg);
        base = sheet_base_reg + g * w + (g / r) * r * w * (h - 1);
        pos = segment_reg * 32'h1000 + (int'(pen_row) << 6) + int'(pen_col);
        for (int unsigned cx = 0; cx < w; cx++) begin
          for (int unsigned cy = 0; cy < h; cy++) begin
            tile = base + cx + cy * r * w;
            c.addr = 16'(pos + cx + (cy << 6));
            c.word = 16'(tile) | {pal_reg, 14'd0};
            c.tail = (cx == w - 1) && (cy == h - 1);
            cells_due.push_back(c);
          end
        end
        pen_col = 8'(int'(pen_col) + w);
        if (pen_col >= WRAP_COLUMN) pen_newline(h);
      end
    endcase
  endtask

  always @(posedge clk_i) begin : text_driver
    text_req_t cur_req;
    bit fire;
    if (rst_ni) begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) render_char(cur_req);
      if (!s_axis_tvalid || fire) begin
        if (text_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = text_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'd0, cur_req.code, cur_req.row, cur_req.col};
          s_axis_tuser <= cur_req.open;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : cell_monitor
    map_cell_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cells_due.size() == 0) begin
          flag_mismatch("unexpected cell write", m_axis_tdata, 32'd0);
        end else begin
          want = cells_due.pop_front();
          if (m_axis_tdata[15:0] !== want.addr)
            flag_mismatch("cell_address", m_axis_tdata[15:0], want.addr);
          if (m_axis_tdata[31:16] !== want.word)
            flag_mismatch("cell_word", m_axis_tdata[31:16], want.word);
          if (m_axis_tlast !== want.tail)
            flag_mismatch("last_cell", m_axis_tlast, want.tail);
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write with junk above the field, then read it back
  task automatic cfg_write(input ttmw_reg_e which, input logic [31:0] val);
    logic [31:0] mask, rd;
    case (which)
      REG_FONT_WIDTH, REG_FONT_HEIGHT, REG_MAP_SEGMENT: mask = 32'hF;
      REG_GLYPHS_PER_ROW: mask = 32'h7F;
      REG_FIRST_CODE:     mask = 32'hFF;
      REG_CHARSET_BASE:   mask = 32'h7FF;
      default:            mask = 32'h3;
    endcase
    apb_xfer(1'b1, {which, 2'b00}, ($urandom & ~mask) | (val & mask), rd);
    case (which)
      REG_FONT_WIDTH:     glyph_w_reg = 4'(val);
      REG_FONT_HEIGHT:    glyph_h_reg = 4'(val);
      REG_GLYPHS_PER_ROW: sheet_stride_reg = 7'(val);
      REG_FIRST_CODE:     base_code_reg = 8'(val);
      REG_CHARSET_BASE:   sheet_base_reg = 11'(val);
      REG_PALETTE:        pal_reg = 2'(val);
      default:            segment_reg = 4'(val);
    endcase
    apb_xfer(1'b0, {which, 2'b00}, 32'd0, rd);
    if (rd !== (val & mask)) flag_mismatch("register readback", rd, val & mask);
  endtask

  task automatic load_font(input int unsigned w, h, r, fc, cb, pal, seg);
    cfg_write(REG_FONT_WIDTH, w);
    cfg_write(REG_FONT_HEIGHT, h);
    cfg_write(REG_GLYPHS_PER_ROW, r);
    cfg_write(REG_FIRST_CODE, fc);
    cfg_write(REG_CHARSET_BASE, cb);
    cfg_write(REG_PALETTE, pal);
    cfg_write(REG_MAP_SEGMENT, seg);
  endtask

  task automatic push_req(input logic open, input logic [5:0] col, input logic [5:0] row,
                          input logic [7:0] code);
    text_req_t rq;
    rq.open = open;
    rq.col = col;
    rq.row = row;
    rq.code = code;
    text_backlog.push_back(rq);
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 8'($urandom_range(32, 126));
    if (sel < 72) return 8'($urandom);
    if (sel < 80) return CODE_TAB;
    if (sel < 88) return CODE_NEWLINE;
    if (sel < 93) return CODE_RETURN;
    if (sel < 95) return CODE_END;
    return 8'($urandom_range(1, 255));
  endfunction

  // strings opened by a start request, now and then preceded by stray requests
  task automatic gen_text(input int unsigned n_chars, input int unsigned max_len);
    int unsigned made, len;
    logic [5:0] col, row;
    made = 0;
    while (made < n_chars) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) push_req(1'b0, 6'($urandom), 6'($urandom), 8'($urandom));
      len = $urandom_range(1, max_len);
      col = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 47)) : 6'($urandom_range(48, 63));
      row = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 27)) : 6'($urandom_range(28, 63));
      push_req(1'b1, col, row, pick_code());
      repeat (len - 1) push_req(1'b0, 6'($urandom), 6'($urandom), pick_code());
      made += len;
    end
  endtask

  // hold until every request is in and every cell write is out, then let the block go idle
  task automatic settle_block();
    while (text_backlog.size() != 0 || s_axis_tvalid || cells_due.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin : main_seq
    logic [31:0] rd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: halted start, stop tests, end code, wraps
    push_req(1'b0, 6'd63, 6'd63, 8'h41);
    push_req(1'b1, 6'd0, 6'd0, 8'h41);
    push_req(1'b0, 6'd0, 6'd0, 8'hFF);
    push_req(1'b0, 6'd0, 6'd0, 8'h01);
    push_req(1'b0, 6'd0, 6'd0, CODE_TAB);
    push_req(1'b0, 6'd0, 6'd0, CODE_RETURN);
    push_req(1'b0, 6'd0, 6'd0, CODE_NEWLINE);
    push_req(1'b0, 6'd0, 6'd0, 8'h20);
    push_req(1'b1, 6'd63, 6'd63, 8'h42);
    push_req(1'b0, 6'd0, 6'd0, 8'h43);
    push_req(1'b1, 6'd47, 6'd27, 8'h5A);
    push_req(1'b0, 6'd0, 6'd0, 8'h5B);
    push_req(1'b1, 6'd5, 6'd3, CODE_END);
    push_req(1'b0, 6'd0, 6'd0, 8'h78);
    push_req(1'b1, 6'd46, 6'd10, CODE_TAB);
    push_req(1'b0, 6'd0, 6'd0, 8'h61);
    push_req(1'b1, 6'd0, 6'd27, CODE_NEWLINE);
    push_req(1'b0, 6'd0, 6'd0, 8'h61);
    push_req(1'b1, 6'd47, 6'd0, 8'h7E);
    push_req(1'b1, 6'd0, 6'd28, 8'h41);
    push_req(1'b1, 6'd48, 6'd0, 8'h41);
    settle_block();

    // no idling on either side for this whole stretch
    calm = 1'b1;
    load_font(1, 1, 32, 32, 0, 0, 0);
    gen_text(90, 14);
    settle_block();
    calm = 1'b0;

    apb_xfer(1'b1, ADDR_SPARE, $urandom, rd);
    load_font(2, 3, 16, 8'h41, 11'h123, 1, 3);
    gen_text(70, 12);
    settle_block();

    // zero width and row stride clamp up, oversize height clamps down
    load_font(0, 15, 0, 255, 2047, 3, 15);
    gen_text(40, 10);
    settle_block();

    load_font(8, 8, 64, 0, 2047, 2, 15);
    gen_text(15, 4);
    settle_block();

    // wide font: tab stops run past 255 and wrap
    load_font(15, 1, 127, 32, 0, 0, 0);
    push_req(1'b1, 6'd44, 6'd0, CODE_TAB);
    push_req(1'b0, 6'd0, 6'd0, 8'h41);
    gen_text(40, 8);
    settle_block();

    load_font($urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 127),
              $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 3),
              $urandom_range(0, 15));
    gen_text(50, 12);
    settle_block();

    calm = 1'b1;
    load_font(3, 2, 5, $urandom_range(0, 255), $urandom_range(0, 2047),
              $urandom_range(0, 3), $urandom_range(0, 15));
    gen_text(40, 12);
    settle_block();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== text_to_tile_map_writer.f =====
+incdir+rtl
rtl/ttmw_pkg.sv
rtl/ttmw_ctrl.sv
rtl/ttmw_dp.sv
rtl/text_to_tile_map_writer.sv
tb/testbench.sv
